@@ rtl/core/ansi_escape_sequence_parser_macros.svh @@
// assertion macros shared by the parser modules
`ifndef ANSI_ESCAPE_SEQUENCE_PARSER_MACROS_SVH
`define ANSI_ESCAPE_SEQUENCE_PARSER_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define AESP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define AESP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define AESP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define AESP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ rtl/core/aesp_pkg.sv @@
package aesp_pkg;

	// parser states
	typedef enum logic [2:0] {
		PS_GROUND,
		PS_ESC,
		PS_ESC_INT,
		PS_CSI_ENTRY,
		PS_CSI_PARAM,
		PS_CSI_INT,
		PS_CSI_IGNORE
	} parse_state_t;

	// operations passed from the front end to the back end
	typedef enum logic [1:0] {
		OP_PRINT,
		OP_WRITE,
		OP_CLEAR,
		OP_DISPATCH
	} op_t;

	// result kinds on the output stream
	typedef enum logic [1:0] {
		EV_PRINT,
		EV_ESC_DISPATCH,
		EV_CSI_DISPATCH
	} event_kind_t;

	// back end sequencer states
	typedef enum logic {
		BS_IDLE,
		BS_RUN
	} back_state_t;

	// byte codes
	localparam logic [7:0] C_ESC        = 8'h1B;
	localparam logic [7:0] C_CSI_OPEN   = 8'h5B;
	localparam logic [7:0] C_SEMI       = 8'h3B;
	localparam logic [7:0] C_COLON      = 8'h3A;
	localparam logic [7:0] C_DEL        = 8'h7F;
	localparam logic [7:0] C_FINAL_LO   = 8'h40;
	localparam logic [7:0] C_PRINT_HI   = 8'h7E;
	localparam logic [7:0] C_INTER_HI   = 8'h2F;
	localparam logic [7:0] C_SPACE      = 8'h20;
	localparam logic [7:0] C_DIGIT0     = 8'h30;
	localparam logic [7:0] C_PRIVATE_LO = 8'h3C;

	// entries in the queue between front and back
	localparam int QUEUE_DEPTH = 4;

endpackage

@@ rtl/core/aesp_front.sv @@
`include "ansi_escape_sequence_parser_macros.svh"

module aesp_front
	import aesp_pkg::*;
#(
	parameter int NUM_SLOTS  = 16,
	parameter int SLOT_WIDTH = 16,
	localparam int IW = $clog2(NUM_SLOTS + 1),
	localparam int QW = 12 + IW + SLOT_WIDTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          byte_valid,
	output logic          byte_ready,
	input  logic [7:0]    byte_data,
	output logic          push,
	output logic [QW-1:0] push_data,
	input  logic          q_full
);

	typedef struct packed {
		op_t                   op;
		event_kind_t           kind;
		logic [7:0]            ch;
		logic [IW-1:0]         idx;
		logic [SLOT_WIDTH-1:0] val;
	} q_entry_t;

	parse_state_t          state_q, state_d;
	logic [IW-1:0]         idx_q, idx_d;
	logic [SLOT_WIDTH-1:0] acc_q, acc_d;
	logic [SLOT_WIDTH+3:0] acc_x10;
	q_entry_t              ent;
	logic                  do_push;
	logic                  do_collect, do_digit, do_semi, do_disp;
	event_kind_t           disp_kind;
	logic                  room;
	logic                  accept;
	logic                  in_band;
	logic                  esc_final;

	assign byte_ready = !q_full;
	assign accept     = byte_valid && byte_ready;
	assign room       = idx_q < IW'(NUM_SLOTS);
	assign push       = accept && do_push;
	assign push_data  = ent;

	// bytes that CSI states look at
	assign in_band = (byte_data >= C_SPACE) && (byte_data < C_DEL);

	// final bytes accepted straight after ESC
	assign esc_final = ((byte_data >= 8'h30) && (byte_data <= 8'h4F)) ||
		((byte_data >= 8'h51) && (byte_data <= 8'h57)) ||
		(byte_data == 8'h59) || (byte_data == 8'h5A) || (byte_data == 8'h5C) ||
		((byte_data >= 8'h60) && (byte_data <= C_PRINT_HI));

	// decimal accumulate of the current slot
	assign acc_x10 = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} +
		(SLOT_WIDTH + 4)'(byte_data[3:0]);

	// classify the byte and pick the action
	always_comb begin
		state_d    = state_q;
		idx_d      = idx_q;
		acc_d      = acc_q;
		do_push    = 1'b0;
		do_collect = 1'b0;
		do_digit   = 1'b0;
		do_semi    = 1'b0;
		do_disp    = 1'b0;
		disp_kind  = EV_CSI_DISPATCH;
		ent.op     = OP_PRINT;
		ent.kind   = EV_PRINT;
		ent.ch     = byte_data;
		ent.idx    = '0;
		ent.val    = '0;
		if (byte_data == C_ESC) begin
			state_d = PS_ESC;
			idx_d   = '0;
			acc_d   = '0;
			do_push = 1'b1;
			ent.op  = OP_CLEAR;
		end else begin
			case (state_q)
				PS_CSI_ENTRY, PS_CSI_PARAM, PS_CSI_INT, PS_CSI_IGNORE: begin
					if (in_band) begin
						if (state_q == PS_CSI_IGNORE) begin
							if (byte_data >= C_FINAL_LO)
								state_d = PS_GROUND;
						end else if (byte_data >= C_FINAL_LO) begin
							do_disp   = 1'b1;
							disp_kind = EV_CSI_DISPATCH;
						end else if (byte_data <= C_INTER_HI) begin
							do_collect = 1'b1;
							state_d    = PS_CSI_INT;
						end else if (state_q == PS_CSI_INT) begin
							state_d = PS_CSI_IGNORE;
						end else if (byte_data == C_COLON) begin
							state_d = PS_CSI_IGNORE;
						end else if (byte_data >= C_PRIVATE_LO) begin
							if (state_q == PS_CSI_ENTRY) begin
								do_collect = 1'b1;
								state_d    = PS_CSI_PARAM;
							end else begin
								state_d = PS_CSI_IGNORE;
							end
						end else begin
							do_semi  = (byte_data == C_SEMI);
							do_digit = (byte_data != C_SEMI);
							state_d  = PS_CSI_PARAM;
						end
					end
				end
				PS_ESC: begin
					if (byte_data == C_CSI_OPEN) begin
						state_d = PS_CSI_ENTRY;
					end else if ((byte_data >= C_SPACE) && (byte_data <= C_INTER_HI)) begin
						do_collect = 1'b1;
						state_d    = PS_ESC_INT;
					end else if (esc_final) begin
						do_disp   = 1'b1;
						disp_kind = EV_ESC_DISPATCH;
					end
				end
				PS_ESC_INT: begin
					if ((byte_data >= C_SPACE) && (byte_data <= C_INTER_HI)) begin
						do_collect = 1'b1;
					end else if ((byte_data >= C_DIGIT0) && (byte_data <= C_PRINT_HI)) begin
						do_disp   = 1'b1;
						disp_kind = EV_ESC_DISPATCH;
					end
				end
				default: begin
					state_d = PS_GROUND;
					if ((byte_data >= C_SPACE) && (byte_data != C_DEL))
						do_push = 1'b1;
				end
			endcase

			// store a private or intermediate byte in the current slot
			if (do_collect && room) begin
				do_push = 1'b1;
				ent.op  = OP_WRITE;
				ent.idx = idx_q;
				ent.val = SLOT_WIDTH'(byte_data);
				idx_d   = idx_q + 1'b1;
				acc_d   = '0;
			end

			// separator closes the current slot
			if (do_semi && room) begin
				do_push = 1'b1;
				ent.op  = OP_WRITE;
				ent.idx = idx_q;
				ent.val = acc_q;
				idx_d   = idx_q + 1'b1;
				acc_d   = '0;
			end

			// digit, saturating
			if (do_digit && room) begin
				if (|acc_x10[SLOT_WIDTH+3:SLOT_WIDTH])
					acc_d = '1;
				else
					acc_d = acc_x10[SLOT_WIDTH-1:0];
			end

			// final byte, the open slot travels with the word
			if (do_disp) begin
				do_push  = 1'b1;
				ent.op   = OP_DISPATCH;
				ent.kind = disp_kind;
				ent.idx  = idx_q;
				ent.val  = acc_q;
				state_d  = PS_GROUND;
				idx_d    = '0;
				acc_d    = '0;
			end
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PS_GROUND;
			idx_q   <= '0;
			acc_q   <= '0;
		end else if (accept) begin
			state_q <= state_d;
			idx_q   <= idx_d;
			acc_q   <= acc_d;
		end
	end

	`AESP_ASSERT_NXT(a_esc_enters_escape, clk, arst_n, accept && (byte_data == C_ESC), state_q == PS_ESC, "ESC did not enter escape state")
	`AESP_ASSERT_IMP(a_slot_index_range, clk, arst_n, 1'b1, idx_q <= IW'(NUM_SLOTS), "slot index past slot count")
	`AESP_ASSERT_NXT(a_dispatch_clears, clk, arst_n, push && (ent.op == OP_DISPATCH), (idx_q == '0) && (acc_q == '0), "dispatch left slot state")

endmodule

@@ rtl/core/aesp_fifo.sv @@
module aesp_fifo
	import aesp_pkg::*;
#(
	parameter int WIDTH = 32,
	parameter int DEPTH = QUEUE_DEPTH,
	localparam int PW = $clog2(DEPTH),
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             head_valid,
	output logic [WIDTH-1:0] head_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full       = count_q == CW'(DEPTH);
	assign head_valid = count_q != '0;
	assign head_data  = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

@@ rtl/core/aesp_back.sv @@
`include "ansi_escape_sequence_parser_macros.svh"

module aesp_back
	import aesp_pkg::*;
#(
	parameter int NUM_SLOTS  = 16,
	parameter int SLOT_WIDTH = 16,
	localparam int IW = $clog2(NUM_SLOTS + 1),
	localparam int AW = $clog2(NUM_SLOTS),
	localparam int QW = 12 + IW + SLOT_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  head_valid,
	input  logic [QW-1:0]         head_data,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output event_kind_t           out_kind,
	output logic [7:0]            out_byte,
	output logic [AW-1:0]         out_num,
	output logic [SLOT_WIDTH-1:0] out_val,
	output logic                  out_last
);

	typedef struct packed {
		op_t                   op;
		event_kind_t           kind;
		logic [7:0]            ch;
		logic [IW-1:0]         idx;
		logic [SLOT_WIDTH-1:0] val;
	} q_entry_t;

	q_entry_t              head;
	back_state_t           state_q, state_d;
	logic [AW-1:0]         k_q, k_d;
	logic [SLOT_WIDTH-1:0] slot_mem [NUM_SLOTS];
	logic [NUM_SLOTS-1:0]  vld_q;
	logic [AW-1:0]         last_k;
	logic [SLOT_WIDTH-1:0] rd_val;
	logic                  load_ok, load, wr_en, clr;
	logic [AW-1:0]         ld_num;
	logic [SLOT_WIDTH-1:0] ld_val;
	logic                  ld_last;
	logic                  out_valid_q;

	assign head      = q_entry_t'(head_data);
	assign load_ok   = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// last slot of the run: the open slot, or the top one when all are used
	assign last_k = (head.idx == IW'(NUM_SLOTS)) ? AW'(NUM_SLOTS - 1) : head.idx[AW-1:0];

	// slot value: open slot from the word, others from the register file
	assign rd_val = (IW'(k_q) == head.idx) ? head.val :
		(vld_q[k_q] ? slot_mem[k_q] : '0);

	// sequencer next state and controls
	always_comb begin
		state_d = state_q;
		k_d     = k_q;
		pop     = 1'b0;
		load    = 1'b0;
		wr_en   = 1'b0;
		clr     = 1'b0;
		ld_num  = '0;
		ld_val  = '0;
		ld_last = 1'b0;
		case (state_q)
			BS_IDLE: begin
				if (head_valid) begin
					case (head.op)
						OP_PRINT: begin
							if (load_ok) begin
								load    = 1'b1;
								ld_last = 1'b1;
								pop     = 1'b1;
							end
						end
						OP_WRITE: begin
							wr_en = 1'b1;
							pop   = 1'b1;
						end
						OP_CLEAR: begin
							clr = 1'b1;
							pop = 1'b1;
						end
						OP_DISPATCH: begin
							state_d = BS_RUN;
							k_d     = '0;
						end
						default: pop = 1'b1;
					endcase
				end
			end
			BS_RUN: begin
				if (load_ok) begin
					load   = 1'b1;
					ld_num = k_q;
					ld_val = rd_val;
					if (k_q == last_k) begin
						ld_last = 1'b1;
						clr     = 1'b1;
						pop     = 1'b1;
						state_d = BS_IDLE;
					end else begin
						k_d = k_q + 1'b1;
					end
				end
			end
			default: state_d = BS_IDLE;
		endcase
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BS_IDLE;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
		end
	end

	// slot register file
	always_ff @(posedge clk) begin
		if (wr_en)
			slot_mem[head.idx[AW-1:0]] <= head.val;
	end

	// slot valid bits, cleared together
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (clr)
			vld_q <= '0;
		else if (wr_en)
			vld_q[head.idx[AW-1:0]] <= 1'b1;
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (load) begin
			out_kind <= head.kind;
			out_byte <= head.ch;
			out_num  <= ld_num;
			out_val  <= ld_val;
			out_last <= ld_last;
		end
	end

	`AESP_ASSERT_IMP(a_run_has_dispatch, clk, arst_n, state_q == BS_RUN, head_valid && (head.op == OP_DISPATCH), "run without dispatch word")
	`AESP_ASSERT_IMP(a_pop_needs_head, clk, arst_n, pop, head_valid, "pop from empty queue")
	`AESP_ASSERT_IMP(a_run_index_range, clk, arst_n, state_q == BS_RUN, k_q <= last_k, "run index past last slot")

endmodule

@@ rtl/core/ansi_escape_sequence_parser.sv @@
// Terminal escape-sequence parser. One byte is taken on s_axis per cycle as long as the
// four-word queue between the parser front end and the result sequencer has room. Results
// leave on m_axis one per cycle while m_axis_tready is high, from an output register: a
// printable ground byte gives one print result, and a final byte gives a dispatch burst of
// min(slot index + 1, NUM_SLOTS) results, one per slot, the last one marked with tlast. While
// a dispatch burst holds the sequencer, the front end keeps parsing until the queue is full.
// After reset the slots read as zero; no clearing pass is needed.
module ansi_escape_sequence_parser
	import aesp_pkg::*;
#(
	parameter int NUM_SLOTS  = 16,
	parameter int SLOT_WIDTH = 16,
	localparam int IW  = $clog2(NUM_SLOTS + 1),
	localparam int AW  = $clog2(NUM_SLOTS),
	localparam int QW  = 12 + IW + SLOT_WIDTH,
	localparam int TDW = ((8 + AW + SLOT_WIDTH + 7) / 8) * 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_axis_tvalid,
	output logic           s_axis_tready,
	input  logic [7:0]     s_axis_tdata,   // in_byte
	output logic           m_axis_tvalid,
	input  logic           m_axis_tready,
	output logic [TDW-1:0] m_axis_tdata,   // event_byte, slot_number, slot_value, zero fill
	output logic [1:0]     m_axis_tuser,   // event_kind
	output logic           m_axis_tlast    // last_of_run
);

	logic                  push, q_full, pop, head_valid;
	logic [QW-1:0]         push_data, head_data;
	event_kind_t           out_kind;
	logic [7:0]            out_byte;
	logic [AW-1:0]         out_num;
	logic [SLOT_WIDTH-1:0] out_val;

	// parser front end
	aesp_front #(
		.NUM_SLOTS  (NUM_SLOTS),
		.SLOT_WIDTH (SLOT_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (s_axis_tvalid),
		.byte_ready (s_axis_tready),
		.byte_data  (s_axis_tdata),
		.push       (push),
		.push_data  (push_data),
		.q_full     (q_full)
	);

	// queue between front and back
	aesp_fifo #(
		.WIDTH (QW),
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_data  (head_data)
	);

	// result sequencer and slot storage
	aesp_back #(
		.NUM_SLOTS  (NUM_SLOTS),
		.SLOT_WIDTH (SLOT_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_data  (head_data),
		.pop        (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_kind   (out_kind),
		.out_byte   (out_byte),
		.out_num    (out_num),
		.out_val    (out_val),
		.out_last   (m_axis_tlast)
	);

	// pack the result word
	assign m_axis_tdata = TDW'({out_val, out_num, out_byte});
	assign m_axis_tuser = out_kind;

endmodule

@@ tb/tb_top.sv @@
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import aesp_pkg::*;

	localparam int NUM_SLOTS      = 16;
	localparam int SLOT_LSB       = 12;
	localparam int SLOT_MAX       = 65535;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 40;
	localparam int LONG_HOLD      = 300;

	// escape finals that open strings and are not dispatched, then further byte codes
	localparam logic [7:0] C_DCS     = 8'h50;
	localparam logic [7:0] C_SOS     = 8'h58;
	localparam logic [7:0] C_OSC     = 8'h5D;
	localparam logic [7:0] C_APC     = 8'h5F;
	localparam logic [7:0] C_DIGIT9  = 8'h39;
	localparam logic [7:0] C_HIGH_LO = 8'h80;

	typedef struct {
		event_kind_t kind;
		logic [7:0]  chr;
		logic [3:0]  slot;
		logic [15:0] value;
		logic        run_end;
	} parser_event_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;   // in_byte
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;           // event_byte, slot_number, slot_value, zero fill
	logic [1:0]  m_axis_tuser;           // event_kind
	logic        m_axis_tlast;           // last_of_run

	ansi_escape_sequence_parser uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	// 2 ns clock
	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	logic [7:0]    byte_queue[$];
	parser_event_t expected_events[$];
	parser_event_t want;
	int            fails = 0;
	int            tx_idle_pct = 0;
	int            rx_idle_pct = 0;
	int            hold_requests = 0;
	int            hold_served = 0;
	int unsigned   rx_hold = 0;
	int unsigned   quiet_cycles = 0;

	// shadow parser state
	parse_state_t  shadow_state = PS_GROUND;
	logic [15:0]   shadow_slots[NUM_SLOTS];
	int unsigned   shadow_index = 0;

	// append a byte to the stimulus queue
	function automatic void put_byte(logic [7:0] c);
		byte_queue.insert(byte_queue.size(), c);
	endfunction

	// append a result to the expected queue
	function automatic void put_event(parser_event_t e);
		expected_events.insert(expected_events.size(), e);
	endfunction

	function automatic void clear_slots();
		foreach (shadow_slots[k])
			shadow_slots[k] = '0;
		shadow_index = 0;
	endfunction

	function automatic void store_code(logic [7:0] c);
		if (shadow_index < NUM_SLOTS) begin
			shadow_slots[shadow_index] = {8'h00, c};
			shadow_index++;
		end
	endfunction

	// semicolon moves to the next slot, digits accumulate with saturation
	function automatic void add_param(logic [7:0] c);
		int unsigned v;
		if (c == C_SEMI) begin
			if (shadow_index < NUM_SLOTS)
				shadow_index++;
		end else if (shadow_index < NUM_SLOTS) begin
			v = 32'(shadow_slots[shadow_index]) * 10 + 32'(c - C_DIGIT0);
			if (v > SLOT_MAX)
				v = SLOT_MAX;
			shadow_slots[shadow_index] = 16'(v);
		end
	endfunction

	function automatic void emit_dispatch(event_kind_t kind, logic [7:0] c);
		int n;
		n = (shadow_index + 1 > NUM_SLOTS) ? NUM_SLOTS : int'(shadow_index) + 1;
		for (int i = 0; i < n; i++)
			put_event('{kind, c, 4'(i), shadow_slots[i], i == n - 1});
		clear_slots();
		shadow_state = PS_GROUND;
	endfunction

	function automatic void predict_byte(logic [7:0] c);
		if (c == C_ESC) begin
			clear_slots();
			shadow_state = PS_ESC;
			return;
		end
		case (shadow_state)
			PS_CSI_ENTRY, PS_CSI_PARAM, PS_CSI_INT, PS_CSI_IGNORE: begin
				if (c < C_SPACE || c >= C_DEL) begin
					// controls, DEL and high bytes are dropped
				end else if (shadow_state == PS_CSI_IGNORE) begin
					if (c >= C_FINAL_LO)
						shadow_state = PS_GROUND;
				end else if (c >= C_FINAL_LO) begin
					emit_dispatch(EV_CSI_DISPATCH, c);
				end else if (c <= C_INTER_HI) begin
					store_code(c);
					shadow_state = PS_CSI_INT;
				end else if (shadow_state == PS_CSI_INT || c == C_COLON) begin
					shadow_state = PS_CSI_IGNORE;
				end else if (c >= C_PRIVATE_LO) begin
					if (shadow_state == PS_CSI_ENTRY) begin
						store_code(c);
						shadow_state = PS_CSI_PARAM;
					end else begin
						shadow_state = PS_CSI_IGNORE;
					end
				end else begin
					add_param(c);
					shadow_state = PS_CSI_PARAM;
				end
			end
			PS_ESC: begin
				if (c == C_CSI_OPEN) begin
					shadow_state = PS_CSI_ENTRY;
				end else if (c >= C_SPACE && c <= C_INTER_HI) begin
					store_code(c);
					shadow_state = PS_ESC_INT;
				end else if (c >= C_DIGIT0 && c <= C_PRINT_HI && c != C_DCS && c != C_SOS
						&& !(c >= C_OSC && c <= C_APC)) begin
					emit_dispatch(EV_ESC_DISPATCH, c);
				end
			end
			PS_ESC_INT: begin
				if (c >= C_SPACE && c <= C_INTER_HI)
					store_code(c);
				else if (c >= C_DIGIT0 && c <= C_PRINT_HI)
					emit_dispatch(EV_ESC_DISPATCH, c);
			end
			default: begin
				shadow_state = PS_GROUND;
				if (c >= C_SPACE && c != C_DEL)
					put_event('{EV_PRINT, c, 4'd0, 16'd0, 1'b1});
			end
		endcase
	endfunction

	// byte that CSI states drop: control, DEL or high byte
	function automatic logic [7:0] dropped_byte();
		case ($urandom_range(2))
			0:       return 8'($urandom_range(0, 31));
			1:       return C_DEL;
			default: return 8'($urandom_range(C_HIGH_LO, 255));
		endcase
	endfunction

	task automatic queue_csi();
		int nparams;
		int ndigits;
		put_byte(C_ESC);
		put_byte(C_CSI_OPEN);
		if ($urandom_range(3) == 0)
			put_byte(8'($urandom_range(C_PRIVATE_LO, C_INTER_HI + 16)));
		nparams = ($urandom_range(7) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 4);
		for (int p = 0; p < nparams; p++) begin
			if (p > 0)
				put_byte(C_SEMI);
			ndigits = ($urandom_range(5) == 0) ? $urandom_range(4, 6) : $urandom_range(0, 2);
			for (int d = 0; d < ndigits; d++)
				put_byte(8'($urandom_range(C_DIGIT0, C_DIGIT9)));
			if ($urandom_range(11) == 0)
				put_byte(dropped_byte());
		end
		if ($urandom_range(4) == 0)
			repeat ($urandom_range(1, 2))
				put_byte(8'($urandom_range(C_SPACE, C_INTER_HI)));
		// broken sequences: colon, late private marker, digit after intermediates, restart
		if ($urandom_range(7) == 0) begin
			case ($urandom_range(3))
				0:       put_byte(C_COLON);
				1:       put_byte(8'($urandom_range(C_PRIVATE_LO, 8'h3F)));
				2:       put_byte(8'($urandom_range(C_DIGIT0, C_SEMI)));
				default: put_byte(C_ESC);
			endcase
		end
		put_byte(8'($urandom_range(C_FINAL_LO, C_PRINT_HI)));
	endtask

	task automatic queue_esc();
		int ninter;
		put_byte(C_ESC);
		if ($urandom_range(4) == 0) begin
			case ($urandom_range(3))
				0:       put_byte(C_DCS);
				1:       put_byte(C_SOS);
				2:       put_byte(8'($urandom_range(C_OSC, C_APC)));
				default: put_byte(dropped_byte());
			endcase
		end
		ninter = ($urandom_range(9) == 0) ? $urandom_range(15, 18) : $urandom_range(0, 2);
		repeat (ninter)
			put_byte(8'($urandom_range(C_SPACE, C_INTER_HI)));
		if (ninter != 0 && $urandom_range(5) == 0)
			put_byte(dropped_byte());
		put_byte(8'($urandom_range(C_DIGIT0, C_PRINT_HI)));
	endtask

	task automatic queue_random(int count);
		int stop;
		stop = byte_queue.size() + count;
		while (byte_queue.size() < stop) begin
			case ($urandom_range(9))
				0, 1, 2, 3: queue_csi();
				4, 5:       queue_esc();
				6, 7:       repeat ($urandom_range(1, 4))
						put_byte(8'($urandom_range(C_SPACE, 255)));
				default:    repeat ($urandom_range(1, 3))
						put_byte(8'($urandom_range(0, 255)));
			endcase
		end
	endtask

	// wait until every queued word is accepted and every result has come back
	task automatic wait_drained();
		while (byte_queue.size() != 0 || s_axis_tvalid || expected_events.size() != 0)
			@(posedge clk);
	endtask

	// input driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= 8'h00;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				predict_byte(s_axis_tdata);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (byte_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= byte_queue.pop_front();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor and receiver back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_events.size() == 0) begin
					$error("unexpected result: kind %0d byte %02h slot %0d value %0d last %0b",
						m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[11:8],
						m_axis_tdata[SLOT_LSB +: 16], m_axis_tlast);
					fails++;
				end else begin
					want = expected_events.pop_front();
					if (m_axis_tuser !== want.kind) begin
						$error("event_kind: expected %0d, got %0d", want.kind, m_axis_tuser);
						fails++;
					end
					if (m_axis_tdata[7:0] !== want.chr) begin
						$error("event_byte: expected %02h, got %02h", want.chr,
							m_axis_tdata[7:0]);
						fails++;
					end
					if (m_axis_tdata[11:8] !== want.slot) begin
						$error("slot_number: expected %0d, got %0d", want.slot,
							m_axis_tdata[11:8]);
						fails++;
					end
					if (m_axis_tdata[SLOT_LSB +: 16] !== want.value) begin
						$error("slot_value: expected %0d, got %0d", want.value,
							m_axis_tdata[SLOT_LSB +: 16]);
						fails++;
					end
					if (m_axis_tlast !== want.run_end) begin
						$error("last_of_run: expected %0b, got %0b", want.run_end,
							m_axis_tlast);
						fails++;
					end
				end
			end
			// long hold-off on request, otherwise random stalls
			if (hold_requests != hold_served) begin
				hold_served = hold_requests;
				rx_hold = LONG_HOLD;
			end
			if (rx_hold != 0) begin
				rx_hold--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// watchdog on words moving on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin
		clear_slots();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// sender mostly busy, receiver mostly stalled
		tx_idle_pct = 19;
		rx_idle_pct = 87;

		// ground: control, high byte, top printable, DEL
		put_byte(8'h00);
		put_byte(8'hFF);
		put_byte(C_PRINT_HI);
		put_byte(C_DEL);
		// plain escape dispatch
		put_byte(C_ESC);
		put_byte(8'h63);
		// escape with intermediates collected into slots
		put_byte(C_ESC);
		put_byte(C_SPACE);
		put_byte(8'h28);
		put_byte(8'h42);
		// private marker followed by a parameter
		put_byte(C_ESC);
		put_byte(C_CSI_OPEN);
		put_byte(8'h3F);
		put_byte(8'h32);
		put_byte(8'h35);
		put_byte(8'h68);
		// parameter saturation
		put_byte(C_ESC);
		put_byte(C_CSI_OPEN);
		repeat (6)
			put_byte(C_DIGIT9);
		put_byte(8'h6D);

		queue_random(50);
		wait_drained();

		// sender mostly idle, receiver mostly ready
		tx_idle_pct = 87;
		rx_idle_pct = 19;
		queue_random(50);
		wait_drained();

		// receiver holds off while the sender keeps offering
		tx_idle_pct = 0;
		hold_requests++;
		queue_random(40);
		wait_drained();

		// no idling
		rx_idle_pct = 0;
		queue_random(50);
		wait_drained();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fails == 0 && expected_events.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/aesp_pkg.sv
rtl/core/aesp_front.sv
rtl/core/aesp_fifo.sv
rtl/core/aesp_back.sv
rtl/core/ansi_escape_sequence_parser.sv
tb/tb_top.sv
